### rtl/cfr_pkg.sv
// Shared types, constants and helpers for the character frequency ranker.
// Used by the top level and the checker of the block; depends on nothing else.
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int CFR_MAX_LEN = 512;
  localparam int CFR_CHARS   = 256;
  localparam int CHAR_W      = 8;
  localparam int COUNT_W     = 10;
  localparam int POS_W       = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 10'd1023;
  localparam logic [CHAR_W-1:0]  SPACE_BYTE = 8'h20;
  localparam logic [CHAR_W-1:0]  UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0]  UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0]  CASE_STEP  = 8'h20;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_FETCH = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_byte;
  } cfr_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ranked_char;
    logic [COUNT_W-1:0] char_count;
    logic               group_end;
    logic               exhausted;
    logic               overflowed;
  } cfr_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN_ADDR,
    ST_SCAN_ORD,
    ST_SCAN_CNT,
    ST_REPLY
  } cfr_state_t;

  typedef enum logic [1:0] {
    PH_FIND,
    PH_LOOK,
    PH_DROP
  } cfr_phase_t;

  function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] r;
    r = b;
    if (b >= UPPER_A && b <= UPPER_Z) begin
      r = b + CASE_STEP;
    end
    return r;
  endfunction

endpackage

### rtl/cfr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the count store and the first-seen list.
`timescale 1ns / 1ps

module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/char_frequency_ranker_core.sv
// Top level of the character frequency ranker: request decode, ranking
// sequencer and reply register. Depends on cfr_pkg and cfr_ram.
`timescale 1ns / 1ps

// Usage: the request channel (req_valid, req_stall, req_data) carries load,
// fetch and clear requests; the reply channel (rsp_valid, rsp_stall,
// rsp_data) carries one reply for each fetch and nothing for other requests.
// A load of a space or a load past capacity is done as it is accepted; any
// other load first reads the byte's count from the count memory, then writes
// back the new count and, for a new byte, its first-seen entry. A clear is
// done as it is accepted. A fetch walks the first-seen list with one read
// of the first-seen memory and one of the count memory for each entry it
// visits, and a pass ends when it reaches the end of the list; when a count
// level runs out, one extra pass over the list finds the next lower level,
// so a fetch visits at most about three times the number of distinct bytes.
// The reply waits in an output register, and loads and clears go on while it
// is stalled; a fetch that finishes while that register is still full holds
// until it is taken.
// Reset empties the store at once: valid bits mask stale counts, so no
// clearing pass is needed.

module char_frequency_ranker_core
  import cfr_pkg::*;
#(
  parameter int MAX_LEN = CFR_MAX_LEN
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  cfr_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output cfr_rsp_t rsp_data
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(CFR_CHARS);

  cfr_state_t state, state_next;
  cfr_phase_t phase, phase_next;

  logic [COUNT_W-1:0] level, level_next;
  logic [COUNT_W-1:0] highest, highest_next;
  logic [COUNT_W-1:0] maxbelow, maxbelow_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [POS_W-1:0]   total, total_next;
  logic [POS_W-1:0]   idx, idx_next;
  logic [LEN_W-1:0]   length, length_next;
  logic               overflow, overflow_next;
  logic [CHAR_W-1:0]  ch, ch_next;
  logic [CHAR_W-1:0]  hit_char, hit_char_next;
  cfr_rsp_t           reply, reply_next;
  logic               rsp_valid_q, rsp_valid_next;
  cfr_rsp_t           rsp_data_q, rsp_data_next;
  logic [CFR_CHARS-1:0] valid_bits;

  logic               req_acc;
  logic               clear_all;
  logic               set_valid;
  logic               cnt_we;
  logic [ADDR_W-1:0]  cnt_raddr;
  logic [COUNT_W-1:0] cnt_rdata;
  logic [COUNT_W-1:0] cnt_wdata;
  logic               ord_we;
  logic [ADDR_W-1:0]  ord_raddr;
  logic [CHAR_W-1:0]  ord_rdata;
  logic [COUNT_W-1:0] cnt_cur;
  logic [COUNT_W-1:0] cnt_inc;

  cfr_ram #(.WIDTH(COUNT_W), .DEPTH(CFR_CHARS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (ch),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  cfr_ram #(.WIDTH(CHAR_W), .DEPTH(CFR_CHARS)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (total[ADDR_W-1:0]),
    .wdata (ch),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  assign req_stall = (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_valid = rsp_valid_q;
  assign rsp_data  = rsp_data_q;

  assign cnt_cur   = valid_bits[ch] ? cnt_rdata : '0;
  assign cnt_inc   = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 10'd1;
  assign cnt_wdata = cnt_inc;

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    level_next     = level;
    highest_next   = highest;
    maxbelow_next  = maxbelow;
    pos_next       = pos;
    total_next     = total;
    idx_next       = idx;
    length_next    = length;
    overflow_next  = overflow;
    ch_next        = ch;
    hit_char_next  = hit_char;
    reply_next     = reply;
    rsp_valid_next = rsp_valid_q && rsp_stall;
    rsp_data_next  = rsp_data_q;
    clear_all      = 1'b0;
    set_valid      = 1'b0;
    cnt_we         = 1'b0;
    ord_we         = 1'b0;
    cnt_raddr      = fold_byte(req_data.char_byte);
    ord_raddr      = idx[ADDR_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          unique case (req_data.kind)
            KIND_LOAD: begin
              pos_next = '0;
              if (length == LEN_W'(MAX_LEN)) begin
                overflow_next = 1'b1;
                level_next    = highest;
              end else if (req_data.char_byte == SPACE_BYTE) begin
                length_next = length + LEN_W'(1);
                level_next  = highest;
              end else begin
                ch_next    = fold_byte(req_data.char_byte);
                state_next = ST_LOAD;
              end
            end
            KIND_FETCH: begin
              if (level == '0) begin
                reply_next = '{ranked_char: '0, char_count: '0, group_end: 1'b0,
                               exhausted: 1'b1, overflowed: overflow};
                state_next = ST_REPLY;
              end else begin
                phase_next = PH_FIND;
                idx_next   = pos;
                state_next = ST_SCAN_ADDR;
              end
            end
            KIND_CLEAR: begin
              clear_all     = 1'b1;
              total_next    = '0;
              length_next   = '0;
              highest_next  = '0;
              level_next    = '0;
              pos_next      = '0;
              overflow_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LOAD: begin
        cnt_we      = 1'b1;
        set_valid   = 1'b1;
        length_next = length + LEN_W'(1);
        if (cnt_cur == '0 && !total[POS_W-1]) begin
          ord_we     = 1'b1;
          total_next = total + POS_W'(1);
        end
        if (cnt_inc > highest) begin
          highest_next = cnt_inc;
          level_next   = cnt_inc;
        end else begin
          level_next = highest;
        end
        state_next = ST_IDLE;
      end

      ST_SCAN_ADDR: begin
        if (idx >= total) begin
          unique case (phase)
            PH_FIND: begin
              phase_next    = PH_DROP;
              idx_next      = '0;
              maxbelow_next = '0;
            end
            PH_LOOK: begin
              reply_next = '{ranked_char: hit_char, char_count: level, group_end: 1'b1,
                             exhausted: 1'b0, overflowed: overflow};
              state_next = ST_REPLY;
            end
            PH_DROP: begin
              level_next = maxbelow;
              pos_next   = '0;
              if (maxbelow == '0) begin
                reply_next = '{ranked_char: '0, char_count: '0, group_end: 1'b0,
                               exhausted: 1'b1, overflowed: overflow};
                state_next = ST_REPLY;
              end else begin
                phase_next = PH_FIND;
                idx_next   = '0;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end else begin
          state_next = ST_SCAN_ORD;
        end
      end

      ST_SCAN_ORD: begin
        cnt_raddr  = ord_rdata;
        ch_next    = ord_rdata;
        state_next = ST_SCAN_CNT;
      end

      ST_SCAN_CNT: begin
        idx_next   = idx + POS_W'(1);
        state_next = ST_SCAN_ADDR;
        unique case (phase)
          PH_FIND: begin
            if (cnt_cur == level) begin
              hit_char_next = ch;
              pos_next      = idx + POS_W'(1);
              phase_next    = PH_LOOK;
            end
          end
          PH_LOOK: begin
            if (cnt_cur == level) begin
              reply_next = '{ranked_char: hit_char, char_count: level, group_end: 1'b0,
                             exhausted: 1'b0, overflowed: overflow};
              state_next = ST_REPLY;
            end
          end
          PH_DROP: begin
            if (cnt_cur < level && cnt_cur > maxbelow) begin
              maxbelow_next = cnt_cur;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_REPLY: begin
        if (!rsp_valid_q || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          rsp_data_next  = reply;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_FIND;
      level       <= '0;
      highest     <= '0;
      pos         <= '0;
      total       <= '0;
      length      <= '0;
      overflow    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      level       <= level_next;
      highest     <= highest_next;
      pos         <= pos_next;
      total       <= total_next;
      length      <= length_next;
      overflow    <= overflow_next;
      rsp_valid_q <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    maxbelow   <= maxbelow_next;
    idx        <= idx_next;
    ch         <= ch_next;
    hit_char   <= hit_char_next;
    reply      <= reply_next;
    rsp_data_q <= rsp_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid_bits <= '0;
    end else if (set_valid) begin
      valid_bits[ch] <= 1'b1;
    end
  end

endmodule

### rtl/cfr_checker.sv
// Port-level checks for the character frequency ranker, bound to the top level.
// Depends on cfr_pkg and char_frequency_ranker_core.
`timescale 1ns / 1ps

module cfr_checker
  import cfr_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input cfr_rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("Stalled reply changed or dropped.");

  a_exhausted_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.exhausted |->
      rsp_data.ranked_char == '0 && rsp_data.char_count == '0 && !rsp_data.group_end)
    else $error("Exhausted reply carries a ranked entry.");

  a_entry_counted: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.exhausted |-> rsp_data.char_count != '0)
    else $error("Ranked entry has a zero count.");

  a_entry_folded: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.exhausted |->
      rsp_data.ranked_char != SPACE_BYTE &&
      (rsp_data.ranked_char < UPPER_A || rsp_data.ranked_char > UPPER_Z))
    else $error("Ranked entry is a space or an unfolded letter.");

endmodule

bind char_frequency_ranker_core cfr_checker u_cfr_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);

### tb/testbench.sv
// Testbench for char_frequency_ranker_core: directed and random request streams with a
// built-in ranking predictor and field-by-field reply checking.
// Depends on cfr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
  import cfr_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 540;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  cfr_req_t req_data;
  logic     rsp_valid;
  logic     rsp_stall;
  cfr_rsp_t rsp_data;

  logic [COUNT_W-1:0] tally [CFR_CHARS];
  logic [CHAR_W-1:0]  arrival [CFR_CHARS];
  int                 n_distinct;
  int                 sent_len;
  logic [COUNT_W-1:0] peak;
  logic [COUNT_W-1:0] scan_level;
  int                 scan_pos;
  logic               dropped;

  cfr_rsp_t expected_replies[$];
  int mismatches = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  char_frequency_ranker_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_store();
    for (int i = 0; i < CFR_CHARS; i++) begin
      tally[i] = '0;
      arrival[i] = '0;
    end
    n_distinct = 0;
    sent_len = 0;
    peak = '0;
    scan_level = '0;
    scan_pos = 0;
    dropped = 1'b0;
  endfunction

  task automatic predict_request(input cfr_req_t r);
    logic [CHAR_W-1:0] b;
    cfr_rsp_t rsp;
    int i;
    bit found;
    bit more;
    case (r.kind)
      KIND_LOAD: begin
        scan_pos = 0;
        if (sent_len >= CFR_MAX_LEN) begin
          dropped = 1'b1;
        end else begin
          sent_len++;
          if (r.char_byte != SPACE_BYTE) begin
            b = r.char_byte;
            if (b >= UPPER_A && b <= UPPER_Z) begin
              b = b + CASE_STEP;
            end
            if (tally[b] == 0 && n_distinct < CFR_CHARS) begin
              arrival[n_distinct] = b;
              n_distinct++;
            end
            if (tally[b] < COUNT_MAX) begin
              tally[b] = tally[b] + 1'b1;
            end
            if (tally[b] > peak) begin
              peak = tally[b];
            end
          end
        end
        scan_level = peak;
      end
      KIND_CLEAR: begin
        clear_store();
      end
      KIND_FETCH: begin
        rsp = '0;
        found = 1'b0;
        while (scan_level > 0 && !found) begin
          i = scan_pos;
          while (i < n_distinct && !found) begin
            if (tally[arrival[i]] == scan_level) begin
              found = 1'b1;
              more = 1'b0;
              for (int j = i + 1; j < n_distinct; j++) begin
                if (tally[arrival[j]] == scan_level) begin
                  more = 1'b1;
                end
              end
              scan_pos = i + 1;
              rsp.ranked_char = arrival[i];
              rsp.char_count = scan_level;
              rsp.group_end = !more;
            end else begin
              i++;
            end
          end
          if (!found) begin
            scan_level = scan_level - 1'b1;
            scan_pos = 0;
          end
        end
        rsp.exhausted = !found;
        rsp.overflowed = dropped;
        expected_replies.push_back(rsp);
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic send_req(input logic [1:0] kind, input logic [CHAR_W-1:0] char_byte);
    cfr_req_t r;
    r.kind = kind;
    r.char_byte = char_byte;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
    predict_request(r);
    items_sent++;
  endtask

  task automatic fetch_times(input int n);
    for (int k = 0; k < n; k++) begin
      send_req(KIND_FETCH, 8'($urandom_range(255)));
    end
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    stall_pct = receiver_pct;
  endtask

  task automatic test_directed_cases();
    logic [CHAR_W-1:0] text [10] = '{8'h41, 8'h61, 8'h5A, 8'h20, 8'h00,
                                     8'h00, 8'hFF, 8'h40, 8'h5B, 8'h7A};
    set_idling(0, 0);
    send_req(KIND_FETCH, 8'h00);
    send_req(KIND_UNUSED, 8'hFF);
    foreach (text[k]) begin
      send_req(KIND_LOAD, text[k]);
    end
    fetch_times(2);
    send_req(KIND_LOAD, 8'h00);
    fetch_times(8);
    send_req(KIND_UNUSED, 8'h00);
    send_req(KIND_CLEAR, 8'hFF);
    send_req(KIND_FETCH, 8'hFF);
  endtask

  task automatic test_capacity_limit();
    set_idling(29, 29);
    send_req(KIND_CLEAR, 8'h00);
    for (int k = 0; k < CFR_MAX_LEN; k++) begin
      send_req(KIND_LOAD, (k % 2 == 0) ? 8'h71 : 8'h51);
    end
    send_req(KIND_FETCH, 8'h00);
    send_req(KIND_LOAD, 8'h78);
    fetch_times(2);
    send_req(KIND_LOAD, SPACE_BYTE);
    send_req(KIND_UNUSED, 8'h55);
    send_req(KIND_FETCH, 8'h00);
    send_req(KIND_CLEAR, 8'h00);
    send_req(KIND_FETCH, 8'h00);
  endtask

  task automatic test_all_byte_values();
    set_idling(0, 0);
    send_req(KIND_CLEAR, 8'h00);
    for (int v = 0; v < CFR_CHARS; v++) begin
      send_req(KIND_LOAD, 8'(v));
    end
    fetch_times(n_distinct + 1);
    send_req(KIND_CLEAR, 8'h00);
  endtask

  task automatic test_random_sentences();
    logic [CHAR_W-1:0] pool [4];
    logic [CHAR_W-1:0] b;
    int stop_at;
    int len;
    int mode;
    int k;
    int n;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      case (((items_sent + RANDOM_ITEMS - stop_at) / (RANDOM_ITEMS / 4)) % 4)
        0: set_idling(0, 0);
        1: set_idling(65, 0);
        2: set_idling(0, 65);
        default: set_idling(29, 29);
      endcase
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(3) != 0) begin
          send_req(KIND_CLEAR, 8'($urandom_range(255)));
        end
        foreach (pool[i]) begin
          pool[i] = 8'($urandom_range(255));
        end
        len = $urandom_range(1, 30);
        mode = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
          k = $urandom_range(5);
          case (mode)
            0: begin
              b = $urandom_range(1) ? 8'(8'h61 + k) : 8'(8'h41 + k);
              if ($urandom_range(4) == 0) begin
                b = SPACE_BYTE;
              end
            end
            1: b = 8'($urandom_range(255));
            default: b = pool[k % 4];
          endcase
          send_req(KIND_LOAD, b);
        end
        n = n_distinct + $urandom_range(2);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(19) == 0) begin
            send_req(KIND_LOAD, pool[$urandom_range(3)]);
          end
          send_req(KIND_FETCH, 8'($urandom_range(255)));
        end
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          send_req(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
      end
    end
  endtask

  always @(negedge clk) begin
    rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cfr_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("reply with no fetch outstanding, char %0h count %0d",
                                  rsp_data.ranked_char, rsp_data.char_count));
      end else begin
        want = expected_replies.pop_front();
        if (rsp_data.ranked_char !== want.ranked_char) begin
          report_mismatch($sformatf("ranked_char got %0h expected %0h",
                                    rsp_data.ranked_char, want.ranked_char));
        end
        if (rsp_data.char_count !== want.char_count) begin
          report_mismatch($sformatf("char_count got %0d expected %0d",
                                    rsp_data.char_count, want.char_count));
        end
        if (rsp_data.group_end !== want.group_end) begin
          report_mismatch($sformatf("group_end got %0b expected %0b",
                                    rsp_data.group_end, want.group_end));
        end
        if (rsp_data.exhausted !== want.exhausted) begin
          report_mismatch($sformatf("exhausted got %0b expected %0b",
                                    rsp_data.exhausted, want.exhausted));
        end
        if (rsp_data.overflowed !== want.overflowed) begin
          report_mismatch($sformatf("overflowed got %0b expected %0b",
                                    rsp_data.overflowed, want.overflowed));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d replies outstanding", expected_replies.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    rsp_stall = 1'b0;
    clear_store();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_capacity_limit();
    test_all_byte_values();
    test_random_sentences();

    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/cfr_pkg.sv
rtl/cfr_ram.sv
rtl/char_frequency_ranker_core.sv
rtl/cfr_checker.sv
tb/testbench.sv
